@@ sv/rlgm_pkg.sv @@
`default_nettype none
package rlgm_pkg;

	localparam int NUM_NT    = 26;
	localparam int ALPHA     = 26;
	localparam int FIELD_W   = 5;
	localparam int ACT_W     = 2;
	localparam int TBL_DEPTH = NUM_NT * ALPHA;
	localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
	localparam int NT_W      = (NUM_NT > 1) ? $clog2(NUM_NT) : 1;
	// entry: next-nonterminal bits [NUM_NT-1:0], terminal-rule bit [NUM_NT]
	localparam int ENTRY_W   = NUM_NT + 1;

	localparam logic [ACT_W-1:0] ACT_ADD_RULE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_SYMBOL   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR    = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RULE_WR,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

@@ sv/right_linear_grammar_matcher_unit.sv @@
// Symbol item: one table read per nonterminal in ST_SCAN, then ST_DRAIN and ST_DONE; an
//   out-of-range letter skips the scan. A last symbol waits in ST_DONE while the result stalls.
// Rule item: read-modify-write of one table entry. Clear item: a sweep of the whole table.
// Items are taken only in ST_IDLE; nothing overlaps apart from a waiting result.
// Reset: asynchronous, active low; then a clearing pass over all TBL_DEPTH entries (676)
//   zeroes the rule table before the first item is taken.
`default_nettype none
module right_linear_grammar_matcher_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [rlgm_pkg::ACT_W-1:0]    action,
	input  wire logic [rlgm_pkg::FIELD_W-1:0]  rule_head,
	input  wire logic [rlgm_pkg::FIELD_W-1:0]  rule_next,
	input  wire logic [rlgm_pkg::FIELD_W-1:0]  letter,
	input  wire logic                          last_symbol,
	// result channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               accepted,
	// start symbol register
	input  wire logic                          cfg_wr_en,
	input  wire logic [rlgm_pkg::FIELD_W-1:0]  cfg_wr_data
);

	import rlgm_pkg::*;

	state_t state_q, state_d;

	// configuration
	logic [FIELD_W-1:0] start_q;

	// rule table port
	logic               mem_we;
	logic [TBL_AW-1:0]  mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic [TBL_AW-1:0]  mem_raddr;
	logic [ENTRY_W-1:0] mem_rdata;

	// word state
	logic [NUM_NT-1:0]  active_q;
	logic               word_open_q;

	// per-item working registers
	logic [TBL_AW-1:0]  clr_cnt_q;
	logic [TBL_AW-1:0]  waddr_q;
	logic [ENTRY_W-1:0] wbits_q;
	logic [TBL_AW-1:0]  scan_addr_q;
	logic [NT_W-1:0]    cnt_q;
	logic [NUM_NT-1:0]  cur_q;
	logic [NUM_NT-1:0]  nset_q;
	logic               acc_q;
	logic               last_q;
	logic               rd_vld_s1;

	// result register
	logic               out_valid_q;
	logic               accepted_q;

	// decode of the incoming item
	logic               take;
	logic               rule_ok;
	logic               sym_ok;
	logic               out_free;
	logic               finish;
	logic [TBL_AW-1:0]  rule_addr;
	logic [ENTRY_W-1:0] rule_bits;
	logic [NUM_NT-1:0]  start_set;

	assign take     = in_valid && (state_q == ST_IDLE);
	assign rule_ok  = (32'(rule_head) < NUM_NT) && (32'(letter) < ALPHA)
	                  && (32'(rule_next) <= NUM_NT);
	assign sym_ok   = (32'(letter) < ALPHA);
	assign out_free = !out_valid_q || !out_stall;
	// a non-final symbol never touches the result register
	assign finish   = (state_q == ST_DONE) && (!last_q || out_free);

	// head * ALPHA + letter; the multiplier is a small constant
	assign rule_addr = TBL_AW'(32'(rule_head) * ALPHA + 32'(letter));

	// one-hot of rule_next; the value NUM_NT lands on the terminal-rule bit
	always_comb begin
		for (int i = 0; i < ENTRY_W; i++) begin
			rule_bits[i] = (32'(rule_next) == i);
		end
	end

	// out-of-range start symbol gives an empty set
	always_comb begin
		for (int i = 0; i < NUM_NT; i++) begin
			start_set[i] = (32'(start_q) == i);
		end
	end

	rlgm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TBL_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = waddr_q;
		mem_wdata = mem_rdata | wbits_q;
		mem_raddr = scan_addr_q;
		unique case (state_q)
			ST_CLEAR: begin
				// sweep the table one entry a cycle
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				mem_wdata = '0;
				if (clr_cnt_q == TBL_AW'(TBL_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall  = 1'b0;
				mem_raddr = rule_addr;
				if (take) begin
					unique case (action)
						ACT_ADD_RULE: state_d = rule_ok ? ST_RULE_WR : ST_IDLE;
						ACT_SYMBOL:   state_d = sym_ok ? ST_SCAN : ST_DONE;
						ACT_CLEAR:    state_d = ST_CLEAR;
						default:      state_d = ST_IDLE;
					endcase
				end
			end
			ST_RULE_WR: begin
				// entry read last cycle; OR in the new rule bit
				mem_we  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (cnt_q == NT_W'(NUM_NT - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (finish) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (cfg_wr_en) begin
			start_q <= cfg_wr_data;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			rd_vld_s1   <= 1'b0;
			active_q    <= '0;
			word_open_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end else if (take && action == ACT_CLEAR) begin
				clr_cnt_q <= '0;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (finish) begin
				if (last_q) begin
					active_q    <= '0;
					word_open_q <= 1'b0;
					out_valid_q <= 1'b1;
				end else begin
					active_q    <= nset_q;
					word_open_q <= 1'b1;
				end
			end
		end
	end

	// datapath registers: the shared OR-accumulate over the active nonterminals
	always_ff @(posedge clk) begin
		if (take) begin
			waddr_q     <= rule_addr;
			wbits_q     <= rule_bits;
			last_q      <= last_symbol;
			cur_q       <= word_open_q ? active_q : start_set;
			nset_q      <= '0;
			acc_q       <= 1'b0;
			cnt_q       <= '0;
			scan_addr_q <= TBL_AW'(letter);
		end
		if (state_q == ST_SCAN) begin
			cnt_q       <= cnt_q + 1'b1;
			scan_addr_q <= scan_addr_q + TBL_AW'(ALPHA);
		end
		// entry for the nonterminal at cur_q[0] is on the read port now
		if (rd_vld_s1) begin
			if (cur_q[0]) begin
				nset_q <= nset_q | mem_rdata[NUM_NT-1:0];
				acc_q  <= acc_q | mem_rdata[NUM_NT];
			end
			cur_q <= cur_q >> 1;
		end
		if (finish && last_q) begin
			accepted_q <= acc_q;
		end
	end

	assign out_valid = out_valid_q;
	assign accepted  = accepted_q;

	// checks
	property p_result_from_done;
		@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE) && $past(last_q);
	endproperty
	a_result_from_done: assert property (p_result_from_done)
		else $error("result raised outside the final step of a last symbol");

	property p_word_closed;
		@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> !word_open_q && (active_q == '0);
	endproperty
	a_word_closed: assert property (p_word_closed)
		else $error("word still open after its result");

	property p_read_tagged;
		@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(state_q == ST_SCAN);
	endproperty
	a_read_tagged: assert property (p_read_tagged)
		else $error("table data absorbed without a scan read");

	property p_drain_has_data;
		@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> rd_vld_s1 && (cnt_q == NT_W'(NUM_NT - 1) + NT_W'(1));
	endproperty
	a_drain_has_data: assert property (p_drain_has_data)
		else $error("scan ended with the wrong read count");

endmodule
`default_nettype wire

@@ sv/rlgm_ram.sv @@
`default_nettype none
module rlgm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire
